>>> rtl/frame_budget_credit_governor_macros.svh
`ifndef FRAME_BUDGET_CREDIT_GOVERNOR_MACROS_SVH
`define FRAME_BUDGET_CREDIT_GOVERNOR_MACROS_SVH

// property checked while out of reset
`define FBCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked through reset as well
`define FBCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fbcg_pkg.sv
package fbcg_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam int BASE_W = 24;
  localparam int EFF_W  = 27;
  localparam int WORD_W = 32;
  localparam int THR_W  = 48;

  localparam logic [BASE_W-1:0] DEFAULT_BASE = 24'd16667;
  localparam logic [EFF_W-1:0]  EFF_MAX      = {EFF_W{1'b1}};
  localparam logic [WORD_W-1:0] WORD_MAX     = {WORD_W{1'b1}};

  typedef struct packed {
    logic load_in;
    logic prep;
    logic upd;
    logic post;
    logic div_start;
    logic div_step;
    logic avg_load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/fbcg_in_if.sv
interface fbcg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] amount;

  modport source (output valid, output operation, output amount, input ready);
  modport sink (input valid, input operation, input amount, output ready);
endinterface

>>> rtl/fbcg_out_if.sv
interface fbcg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_number;
  logic        spend_allowed;
  logic [26:0] effective_budget;
  logic [31:0] frame_count;
  logic [31:0] overrun_count;
  logic [31:0] average_time;
  logic [31:0] peak_time;
  logic [47:0] throttled_total;
  logic        frame_open;

  modport source (
    output valid, output frame_number, output spend_allowed, output effective_budget,
    output frame_count, output overrun_count, output average_time, output peak_time,
    output throttled_total, output frame_open, input ready
  );
  modport sink (
    input valid, input frame_number, input spend_allowed, input effective_budget,
    input frame_count, input overrun_count, input average_time, input peak_time,
    input throttled_total, input frame_open, output ready
  );
endinterface

>>> rtl/fbcg_ctrl.sv
module fbcg_ctrl
  import fbcg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_POST;
      end
      ST_POST: begin
        cmd.post = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fbcg_dp.sv
module fbcg_dp
  import fbcg_pkg::*;
#(
  parameter int CREDIT_MULTIPLE = 4,
  parameter int SUM_WIDTH       = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata,
  input  logic [1:0]        in_operation,
  input  logic [WORD_W-1:0] in_amount,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_frame_number,
  output logic              out_spend_allowed,
  output logic [EFF_W-1:0]  out_effective_budget,
  output logic [WORD_W-1:0] out_frame_count,
  output logic [WORD_W-1:0] out_overrun_count,
  output logic [WORD_W-1:0] out_average_time,
  output logic [WORD_W-1:0] out_peak_time,
  output logic [THR_W-1:0]  out_throttled_total,
  output logic              out_frame_open
);

  localparam int CNT_W = $clog2(SUM_WIDTH + 1);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  logic [BASE_W-1:0]    base_r;
  logic [EFF_W-1:0]     credit_r;
  logic [WORD_W-1:0]    elapsed_r;
  logic                 open_r;
  logic [WORD_W-1:0]    next_fn_r;
  logic [WORD_W-1:0]    frames_r;
  logic [WORD_W-1:0]    overruns_r;
  logic [SUM_WIDTH-1:0] tsum_r;
  logic [WORD_W-1:0]    peak_r;
  logic [SUM_WIDTH-1:0] thr_r;
  logic [WORD_W-1:0]    avg_r;

  logic [1:0]           op_r;
  logic [WORD_W-1:0]    amt_r;
  logic [EFF_W-1:0]     eff_r;
  logic [EFF_W-1:0]     cap_r;
  logic [WORD_W-1:0]    fn_out_r;
  logic                 allowed_r;
  logic                 need_div_r;
  logic [EFF_W-1:0]     eff_out_r;

  logic [WORD_W-1:0]    rem_r;
  logic [SUM_WIDTH-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;

  logic                 out_valid_r;
  logic [WORD_W-1:0]    o_fn_r;
  logic                 o_allowed_r;
  logic [EFF_W-1:0]     o_eff_r;
  logic [WORD_W-1:0]    o_frames_r;
  logic [WORD_W-1:0]    o_overruns_r;
  logic [WORD_W-1:0]    o_avg_r;
  logic [WORD_W-1:0]    o_peak_r;
  logic [THR_W-1:0]     o_thr_r;
  logic                 o_open_r;

  logic [BASE_W-1:0]    base_val;
  logic [EFF_W:0]       eff_sum;
  logic [EFF_W-1:0]     eff_now;
  logic [WORD_W-1:0]    cap_full;
  logic [EFF_W:0]       credit_sum;
  logic [WORD_W:0]      query_sum;
  logic [WORD_W-1:0]    used;
  logic [SUM_WIDTH:0]   tsum_add;
  logic [SUM_WIDTH:0]   thr_add;
  logic [WORD_W:0]      rem_sh;
  logic                 rem_ge;

  always_comb begin
    base_val   = (base_r == '0) ? DEFAULT_BASE : base_r;
    eff_sum    = {1'b0, credit_r} + (EFF_W + 1)'(base_val);
    eff_now    = eff_sum[EFF_W] ? EFF_MAX : eff_sum[EFF_W-1:0];
    cap_full   = WORD_W'(base_val) * WORD_W'(CREDIT_MULTIPLE);
    credit_sum = {1'b0, credit_r} + {1'b0, eff_r - amt_r[EFF_W-1:0]};
    used       = open_r ? elapsed_r : '0;
    query_sum  = {1'b0, used} + {1'b0, amt_r};
    tsum_add   = {1'b0, tsum_r} + (SUM_WIDTH + 1)'(amt_r);
    thr_add    = {1'b0, thr_r} + (SUM_WIDTH + 1)'(amt_r);
    rem_sh     = {rem_r, quo_r[SUM_WIDTH-1]};
    rem_ge     = rem_sh >= {1'b0, frames_r};
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= DEFAULT_BASE;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // item capture and budget preparation
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      amt_r <= in_amount;
    end
    if (cmd.prep) begin
      eff_r <= eff_now;
      cap_r <= (|cap_full[WORD_W-1:EFF_W]) ? EFF_MAX : cap_full[EFF_W-1:0];
    end
    if (cmd.upd) begin
      fn_out_r <= next_fn_r;
    end
    if (cmd.post) begin
      eff_out_r <= eff_now;
    end
  end

  // governor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r   <= '0;
      elapsed_r  <= '0;
      open_r     <= 1'b0;
      next_fn_r  <= '0;
      frames_r   <= '0;
      overruns_r <= '0;
      tsum_r     <= '0;
      peak_r     <= '0;
      thr_r      <= '0;
      allowed_r  <= 1'b0;
      need_div_r <= 1'b0;
    end else if (cmd.upd) begin
      allowed_r  <= (op_r == OP_QUERY) && (query_sum <= (WORD_W + 1)'(eff_r));
      need_div_r <= (op_r == OP_END) && open_r;
      unique case (op_r)
        OP_TICK: begin
          if (open_r && elapsed_r != WORD_MAX) begin
            elapsed_r <= elapsed_r + 1'b1;
          end
        end
        OP_BEGIN: begin
          elapsed_r <= '0;
          open_r    <= 1'b1;
          next_fn_r <= next_fn_r + 1'b1;
        end
        OP_END: begin
          if (open_r) begin
            open_r <= 1'b0;
            if (frames_r != WORD_MAX) begin
              frames_r <= frames_r + 1'b1;
            end
            tsum_r <= tsum_add[SUM_WIDTH] ? SUM_MAX : tsum_add[SUM_WIDTH-1:0];
            if (amt_r > peak_r) begin
              peak_r <= amt_r;
            end
            if (amt_r > WORD_W'(eff_r)) begin
              credit_r <= '0;
              if (overruns_r != WORD_MAX) begin
                overruns_r <= overruns_r + 1'b1;
              end
            end else begin
              credit_r <= (credit_sum > {1'b0, cap_r}) ? cap_r : credit_sum[EFF_W-1:0];
            end
          end
        end
        OP_QUERY: begin
          if (query_sum > (WORD_W + 1)'(eff_r)) begin
            thr_r <= thr_add[SUM_WIDTH] ? SUM_MAX : thr_add[SUM_WIDTH-1:0];
          end
        end
      endcase
    end
  end

  // restoring divider for the average, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= CNT_W'(SUM_WIDTH);
    end else if (cmd.div_step && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= tsum_r;
    end else if (cmd.div_step && cnt_r != '0) begin
      rem_r <= rem_ge ? WORD_W'(rem_sh - {1'b0, frames_r}) : rem_sh[WORD_W-1:0];
      quo_r <= {quo_r[SUM_WIDTH-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (cmd.avg_load) begin
      avg_r <= (quo_r > SUM_WIDTH'(WORD_MAX)) ? WORD_MAX : quo_r[WORD_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_fn_r       <= fn_out_r;
      o_allowed_r  <= allowed_r;
      o_eff_r      <= eff_out_r;
      o_frames_r   <= frames_r;
      o_overruns_r <= overruns_r;
      o_avg_r      <= avg_r;
      o_peak_r     <= peak_r;
      o_thr_r      <= THR_W'(thr_r);
      o_open_r     <= open_r;
    end
  end

  assign sts.need_div = need_div_r;
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_frame_number     = o_fn_r;
  assign out_spend_allowed    = o_allowed_r;
  assign out_effective_budget = o_eff_r;
  assign out_frame_count      = o_frames_r;
  assign out_overrun_count    = o_overruns_r;
  assign out_average_time     = o_avg_r;
  assign out_peak_time        = o_peak_r;
  assign out_throttled_total  = o_thr_r;
  assign out_frame_open       = o_open_r;

endmodule

>>> rtl/frame_budget_credit_governor.sv
// flow: an item passes the states PREP, UPD and POST, then DONE loads the result
//   register once the output is free; an end of an open frame runs the average
//   divider in DIV before DONE. A new item is taken only in IDLE, after that load
// reset: synchronous active-low rst_n clears all counters, credit and sums,
//   closes any frame and loads the base budget with 16667
module frame_budget_credit_governor
  import fbcg_pkg::*;
#(
  parameter int CREDIT_MULTIPLE = 4,
  parameter int SUM_WIDTH       = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata,
  fbcg_in_if.sink           in_ch,
  fbcg_out_if.source        out_ch
);

  cmd_t cmd;
  sts_t sts;

  fbcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbcg_dp #(
    .CREDIT_MULTIPLE (CREDIT_MULTIPLE),
    .SUM_WIDTH       (SUM_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_operation         (in_ch.operation),
    .in_amount            (in_ch.amount),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_frame_number     (out_ch.frame_number),
    .out_spend_allowed    (out_ch.spend_allowed),
    .out_effective_budget (out_ch.effective_budget),
    .out_frame_count      (out_ch.frame_count),
    .out_overrun_count    (out_ch.overrun_count),
    .out_average_time     (out_ch.average_time),
    .out_peak_time        (out_ch.peak_time),
    .out_throttled_total  (out_ch.throttled_total),
    .out_frame_open       (out_ch.frame_open)
  );

endmodule

>>> rtl/fbcg_chk.sv
`include "frame_budget_credit_governor_macros.svh"

module fbcg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_frame_count,
  input logic [31:0] out_overrun_count
);

  `FBCG_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `FBCG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `FBCG_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  `FBCG_ASSERT(a_overrun_le_frames, out_valid |-> out_overrun_count <= out_frame_count,
               "overrun count above frame count")

endmodule

bind frame_budget_credit_governor fbcg_chk u_fbcg_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_frame_count   (out_ch.frame_count),
  .out_overrun_count (out_ch.overrun_count)
);

>>> sim/governor_checker.sv
`timescale 1ns / 100ps

module governor_checker
  import fbcg_pkg::*;
#(
  parameter int CREDIT_MULTIPLE = 4,
  parameter int SUM_WIDTH       = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata,
  fbcg_in_if                in_ch,
  fbcg_out_if               out_ch,
  output int                fault_total
);

  typedef struct {
    logic [WORD_W-1:0] frame_number;
    logic              spend_allowed;
    logic [EFF_W-1:0]  effective_budget;
    logic [WORD_W-1:0] frame_count;
    logic [WORD_W-1:0] overrun_count;
    logic [WORD_W-1:0] average_time;
    logic [WORD_W-1:0] peak_time;
    logic [THR_W-1:0]  throttled_total;
    logic              frame_open;
  } frame_report_t;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  logic [BASE_W-1:0]    base_reg;
  logic [EFF_W-1:0]     credit;
  logic [WORD_W-1:0]    elapsed;
  logic                 frame_active;
  logic [WORD_W-1:0]    next_index;
  logic [WORD_W-1:0]    frames_closed;
  logic [WORD_W-1:0]    overruns;
  logic [SUM_WIDTH-1:0] used_sum;
  logic [WORD_W-1:0]    peak;
  logic [SUM_WIDTH-1:0] refused_sum;

  frame_report_t expected_reports[$];
  int            faults = 0;

  function automatic logic [63:0] base_in_force();
    return (base_reg == '0) ? 64'(DEFAULT_BASE) : 64'(base_reg);
  endfunction

  function automatic logic [63:0] budget_now();
    logic [63:0] total;
    total = base_in_force() + 64'(credit);
    return (total > 64'(EFF_MAX)) ? 64'(EFF_MAX) : total;
  endfunction

  function automatic logic [SUM_WIDTH-1:0] add_clamped(input logic [SUM_WIDTH-1:0] acc,
                                                       input logic [WORD_W-1:0] amt);
    logic [SUM_WIDTH:0] total;
    total = {1'b0, acc} + (SUM_WIDTH + 1)'(amt);
    return total[SUM_WIDTH] ? SUM_MAX : total[SUM_WIDTH-1:0];
  endfunction

  task automatic clear_governor();
    base_reg      = DEFAULT_BASE;
    credit        = '0;
    elapsed       = '0;
    frame_active  = 1'b0;
    next_index    = '0;
    frames_closed = '0;
    overruns      = '0;
    used_sum      = '0;
    peak          = '0;
    refused_sum   = '0;
  endtask

  task automatic apply_item(input logic [1:0] op, input logic [WORD_W-1:0] amt,
                            output frame_report_t rep);
    logic [63:0] eff;
    logic [63:0] cap;
    logic [63:0] banked;
    logic [63:0] avg;
    rep.frame_number  = next_index;
    rep.spend_allowed = 1'b0;
    case (op)
      OP_TICK: begin
        if (frame_active && elapsed != WORD_MAX) elapsed = elapsed + 1'b1;
      end
      OP_BEGIN: begin
        elapsed      = '0;
        frame_active = 1'b1;
        next_index   = next_index + 1'b1;
      end
      OP_END: begin
        if (frame_active) begin
          eff          = budget_now();
          frame_active = 1'b0;
          if (frames_closed != WORD_MAX) frames_closed = frames_closed + 1'b1;
          used_sum = add_clamped(used_sum, amt);
          if (amt > peak) peak = amt;
          if (64'(amt) > eff) begin
            if (overruns != WORD_MAX) overruns = overruns + 1'b1;
            credit = '0;
          end else begin
            cap = base_in_force() * 64'(CREDIT_MULTIPLE);
            if (cap > 64'(EFF_MAX)) cap = 64'(EFF_MAX);
            banked = 64'(credit) + eff - 64'(amt);
            credit = EFF_W'((banked > cap) ? cap : banked);
          end
        end
      end
      default: begin
        if ((frame_active ? 64'(elapsed) : 64'd0) + 64'(amt) <= budget_now()) begin
          rep.spend_allowed = 1'b1;
        end else begin
          refused_sum = add_clamped(refused_sum, amt);
        end
      end
    endcase
    avg = (frames_closed == '0) ? 64'd0 : 64'(used_sum) / 64'(frames_closed);
    if (avg > 64'(WORD_MAX)) avg = 64'(WORD_MAX);
    rep.effective_budget = EFF_W'(budget_now());
    rep.frame_count      = frames_closed;
    rep.overrun_count    = overruns;
    rep.average_time     = avg[WORD_W-1:0];
    rep.peak_time        = peak;
    rep.throttled_total  = THR_W'(refused_sum);
    rep.frame_open       = frame_active;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    frame_report_t rep;
    frame_report_t want;
    if (!rst_n) begin
      clear_governor();
      expected_reports.delete();
    end else begin
      if (cfg_we) base_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        apply_item(in_ch.operation, in_ch.amount, rep);
        expected_reports.push_back(rep);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no item pending");
          faults++;
        end else begin
          want = expected_reports.pop_front();
          check_field("frame_number", 64'(want.frame_number), 64'(out_ch.frame_number));
          check_field("spend_allowed", 64'(want.spend_allowed), 64'(out_ch.spend_allowed));
          check_field("effective_budget", 64'(want.effective_budget),
                      64'(out_ch.effective_budget));
          check_field("frame_count", 64'(want.frame_count), 64'(out_ch.frame_count));
          check_field("overrun_count", 64'(want.overrun_count), 64'(out_ch.overrun_count));
          check_field("average_time", 64'(want.average_time), 64'(out_ch.average_time));
          check_field("peak_time", 64'(want.peak_time), 64'(out_ch.peak_time));
          check_field("throttled_total", 64'(want.throttled_total),
                      64'(out_ch.throttled_total));
          check_field("frame_open", 64'(want.frame_open), 64'(out_ch.frame_open));
        end
      end
    end
    fault_total <= faults + expected_reports.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import fbcg_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [BASE_W-1:0] cfg_wdata;
  int                faults;
  int                n_accepted = 0;
  int                n_returned = 0;
  int                n_offered  = 0;
  int                burst_left = 0;
  int                hold_left  = 0;
  int                holds_done = 0;
  int                rx_mode    = 0;
  int                rx_phase   = 0;
  logic [BASE_W-1:0] base_now;
  logic [BASE_W-1:0] phase_bases[6] = '{24'd50, 24'hFFFFFF, 24'd1, 24'd300, 24'd0, 24'd4000};

  fbcg_in_if  in_bus ();
  fbcg_out_if out_bus ();

  frame_budget_credit_governor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  governor_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .fault_total(faults)
  );

  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) n_accepted <= n_accepted + 1;
    if (out_bus.valid && out_bus.ready) n_returned <= n_returned + 1;
  end

  // receiver: random stall pattern from four modes, plus two long hold-offs
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_phase == 0) rx_mode = $urandom_range(0, 3);
      rx_phase = (rx_phase + 1) % 48;
      if (hold_left == 0 && holds_done < 2 && n_returned >= 300 + 900 * holds_done) begin
        hold_left = 600;
        holds_done++;
      end
      if (!rst_n || hold_left != 0) begin
        out_bus.ready <= 1'b0;
        if (hold_left != 0) hold_left--;
      end else begin
        case (rx_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          2: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] amt);
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.amount    <= amt;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    n_offered++;
  endtask

  task automatic offer(input logic [1:0] op, input logic [31:0] amt);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    burst_left--;
    send_item(op, amt);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (n_returned != n_accepted) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_amount(input logic [BASE_W-1:0] base);
    logic [31:0] b;
    b = (base == '0) ? 32'(DEFAULT_BASE) : 32'(base);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return WORD_MAX;
      2: return $urandom;
      default: return $urandom_range(0, 3 * b);
    endcase
  endfunction

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic run_phase(input int n_items);
    int stop_at;
    int ticks;
    stop_at = n_offered + n_items;
    while (n_offered < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        offer(OP_BEGIN, $urandom);
        ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 12);
        repeat (ticks) begin
          if ($urandom_range(0, 5) == 0) offer(OP_QUERY, pick_amount(base_now));
          offer(OP_TICK, $urandom);
        end
        offer(OP_QUERY, pick_amount(base_now));
        if ($urandom_range(0, 7) != 0) offer(OP_END, pick_amount(base_now));
      end else begin
        offer(2'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_TICK;
    in_bus.amount    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    base_now = '0;
    write_base(base_now);
    offer(OP_TICK, '0);
    offer(OP_END, 32'd1234);
    offer(OP_QUERY, 32'd16667);
    offer(OP_QUERY, 32'd16668);
    offer(OP_BEGIN, WORD_MAX);
    repeat (3) offer(OP_TICK, WORD_MAX);
    offer(OP_QUERY, 32'd16664);
    offer(OP_QUERY, 32'd16665);
    offer(OP_END, 32'd100);
    offer(OP_BEGIN, '0);
    offer(OP_BEGIN, '0);
    offer(OP_QUERY, 32'd33234);
    offer(OP_END, WORD_MAX);
    offer(OP_QUERY, WORD_MAX);
    // three zero-time frames bank credit up to the cap
    repeat (3) begin
      offer(OP_BEGIN, '0);
      offer(OP_END, '0);
    end
    offer(OP_BEGIN, '0);
    offer(OP_END, 32'd83335);
    offer(OP_TICK, '0);

    foreach (phase_bases[i]) begin
      drain();
      base_now = phase_bases[i];
      write_base(base_now);
      run_phase(300);
    end

    drain();

    if (faults == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> frame_budget_credit_governor.f
+incdir+rtl
rtl/fbcg_pkg.sv
rtl/fbcg_in_if.sv
rtl/fbcg_out_if.sv
rtl/fbcg_ctrl.sv
rtl/fbcg_dp.sv
rtl/frame_budget_credit_governor.sv
rtl/fbcg_chk.sv
sim/governor_checker.sv
sim/tb.sv
